// ----- hdl/dwq_pkg.sv -----
// Shared types and constants for the deadline window queue.
package dwq_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ENTRY_W = 3 * WORD_W;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_CHECK   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_DELIVERED = 3'd3,
    ST_FRONT     = 3'd4,
    ST_NOT_YET   = 3'd5,
    ST_EXPIRED   = 3'd6
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_e;

endpackage

// ----- hdl/deadline_window_queue.sv -----
// Top level of the deadline window queue: control, pointers and result register.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------------
//   command  | start / busy        | action_i, package_id_i, window_start_i,
//            |                     | window_end_i, now_time_i
//   result   | valid_o (strobe)    | status_o, out_id_o, out_start_o, out_end_o,
//            |                     | is_last_o
//
// Enqueue, and any action on an empty queue, is answered straight from the idle
// state. Dequeue, peek and check_time first read the head entry from the entry RAM,
// then act on the registered read data. Check_time reads once more for each expired
// head that it drops, since each drop issues the read of the next head. Reset clears
// the head and fill pointers; the RAM holds no reset state. Results cannot be stalled.
module deadline_window_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action_i,
  input  logic signed [31:0]    package_id_i,
  input  logic signed [31:0]    window_start_i,
  input  logic signed [31:0]    window_end_i,
  input  logic signed [31:0]    now_time_i,
  output logic                  valid_o,
  output logic [2:0]            status_o,
  output logic signed [31:0]    out_id_o,
  output logic signed [31:0]    out_start_o,
  output logic signed [31:0]    out_end_o,
  output logic                  is_last_o
);

  import dwq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);

  fsm_e                     state_q, state_d;
  logic [PW-1:0]            head_q, head_d;
  logic [PW-1:0]            fill_q, fill_d;
  logic [PW-1:0]            head_nxt;
  action_e                  act_q, act_d;
  logic signed [WORD_W-1:0] now_q, now_d;

  logic                     valid_q, valid_d;
  status_e                  status_q, status_d;
  logic [WORD_W-1:0]        id_q, id_d;
  logic [WORD_W-1:0]        start_q, start_d;
  logic [WORD_W-1:0]        end_q, end_d;
  logic                     last_q, last_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [WORD_W-1:0]        rd_id;
  logic signed [WORD_W-1:0] rd_start;
  logic signed [WORD_W-1:0] rd_end;
  logic                     accept;
  logic                     empty;

  dwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {package_id_i, window_start_i, window_end_i};
  assign rd_id     = ram_rdata[3*WORD_W-1:2*WORD_W];
  assign rd_start  = ram_rdata[2*WORD_W-1:WORD_W];
  assign rd_end    = ram_rdata[WORD_W-1:0];

  assign accept   = start && (state_q == FSM_IDLE);
  assign empty    = (head_q >= fill_q);
  assign head_nxt = head_q + PW'(1);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    act_d     = act_q;
    now_d     = now_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    id_d      = '0;
    start_d   = '0;
    end_d     = '0;
    last_d    = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = head_q[AW-1:0];

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          act_d = action_e'(action_i);
          now_d = now_time_i;
          case (action_e'(action_i))
            ACT_ENQUEUE: begin
              valid_d = 1'b1;
              last_d  = 1'b1;
              if (fill_q >= PW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ram_we   = 1'b1;
                fill_d   = fill_q + PW'(1);
                status_d = ST_ADDED;
                id_d     = package_id_i;
              end
            end
            default: begin
              if (empty) begin
                valid_d  = 1'b1;
                last_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                // Read issued at the head; act on it next cycle.
                state_d = FSM_READ;
              end
            end
          endcase
        end
      end

      FSM_READ: begin
        valid_d = 1'b1;
        id_d    = rd_id;
        last_d  = 1'b1;
        state_d = FSM_IDLE;
        case (act_q)
          ACT_DEQUEUE: begin
            status_d = ST_DELIVERED;
            head_d   = head_nxt;
          end
          ACT_PEEK: begin
            status_d = ST_FRONT;
            start_d  = rd_start;
            end_d    = rd_end;
          end
          ACT_CHECK: begin
            if (now_q >= rd_start && now_q <= rd_end) begin
              status_d = ST_FRONT;
            end else if (now_q > rd_end) begin
              // Drop the expired head and fetch the next one, if any.
              status_d  = ST_EXPIRED;
              head_d    = head_nxt;
              ram_raddr = head_nxt[AW-1:0];
              if (head_nxt < fill_q) begin
                last_d  = 1'b0;
                state_d = FSM_READ;
              end
            end else begin
              status_d = ST_NOT_YET;
            end
          end
          default: begin
            status_d = ST_EMPTY;
          end
        endcase
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    now_q    <= now_d;
    status_q <= status_d;
    id_q     <= id_d;
    start_q  <= start_d;
    end_q    <= end_d;
    last_q   <= last_d;
  end

  assign busy        = (state_q != FSM_IDLE);
  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign out_id_o    = id_q;
  assign out_start_o = start_q;
  assign out_end_o   = end_q;
  assign is_last_o   = last_q;

`ifndef NO_ASSERTIONS
  a_head_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= fill_q)
    else $error("head pointer passed fill pointer");

  a_fill_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= PW'(DEPTH))
    else $error("fill pointer beyond depth");

  a_head_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q != $past(head_q) |-> head_q == $past(head_q) + PW'(1))
    else $error("head pointer moved by more than one");

  a_enq_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_ENQUEUE |=> valid_o && is_last_o && !busy)
    else $error("enqueue did not finish in one cycle");

  a_more_keeps_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !is_last_o |-> busy)
    else $error("non-final result while idle");
`endif

endmodule

// ----- hdl/dwq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dwq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the deadline window queue.
`timescale 1ns / 1ps

module tb;
  import dwq_pkg::*;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned MID_ITEMS     = 420;
  localparam int unsigned MID_ENQUEUES  = 42;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned LIMIT_CYCLES  = 400_000;
  localparam int unsigned REPORT_CAP    = 200;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    status_e            status;
    logic signed [31:0] id;
    logic signed [31:0] win_start;
    logic signed [31:0] win_end;
    logic               is_last;
  } outcome_t;

  // Mirror of the queue contents; predicts the result transactions of each command.
  class window_queue_scoreboard;
    logic signed [31:0] id_mem[SLOTS];
    logic signed [31:0] start_mem[SLOTS];
    logic signed [31:0] end_mem[SLOTS];
    int unsigned        head_slot;
    int unsigned        fill_slot;
    outcome_t           awaited[$];
    int unsigned        mismatches;
    int unsigned        commands_noted;
    int unsigned        status_hits[8];

    function new();
      head_slot      = 0;
      fill_slot      = 0;
      mismatches     = 0;
      commands_noted = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    function void add_outcome(status_e st, logic signed [31:0] id,
                              logic signed [31:0] ws, logic signed [31:0] we);
      outcome_t o;
      o.status    = st;
      o.id        = id;
      o.win_start = ws;
      o.win_end   = we;
      o.is_last   = 1'b0;
      awaited.push_back(o);
    endfunction

    function void note_command(action_e act, logic signed [31:0] id,
                               logic signed [31:0] ws, logic signed [31:0] we,
                               logic signed [31:0] now);
      logic stop;
      commands_noted++;
      stop = 1'b0;
      case (act)
        ACT_ENQUEUE: begin
          if (fill_slot >= SLOTS) begin
            add_outcome(ST_FULL, '0, '0, '0);
          end else begin
            id_mem[fill_slot]    = id;
            start_mem[fill_slot] = ws;
            end_mem[fill_slot]   = we;
            fill_slot++;
            add_outcome(ST_ADDED, id, '0, '0);
          end
        end
        ACT_DEQUEUE: begin
          if (head_slot >= fill_slot) begin
            add_outcome(ST_EMPTY, '0, '0, '0);
          end else begin
            add_outcome(ST_DELIVERED, id_mem[head_slot], '0, '0);
            head_slot++;
          end
        end
        ACT_PEEK: begin
          if (head_slot >= fill_slot) begin
            add_outcome(ST_EMPTY, '0, '0, '0);
          end else begin
            add_outcome(ST_FRONT, id_mem[head_slot], start_mem[head_slot],
                        end_mem[head_slot]);
          end
        end
        default: begin
          if (head_slot >= fill_slot) add_outcome(ST_EMPTY, '0, '0, '0);
          // drop expired heads until one is deliverable or not yet due
          while (!stop && head_slot < fill_slot) begin
            if (now >= start_mem[head_slot] && now <= end_mem[head_slot]) begin
              add_outcome(ST_FRONT, id_mem[head_slot], '0, '0);
              stop = 1'b1;
            end else if (now > end_mem[head_slot]) begin
              add_outcome(ST_EXPIRED, id_mem[head_slot], '0, '0);
              head_slot++;
            end else begin
              add_outcome(ST_NOT_YET, id_mem[head_slot], '0, '0);
              stop = 1'b1;
            end
          end
        end
      endcase
      awaited[awaited.size() - 1].is_last = 1'b1;
    endfunction

    function void flag(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    function void check_result(logic [2:0] st, logic signed [31:0] id,
                               logic signed [31:0] ws, logic signed [31:0] we,
                               logic last_flag);
      outcome_t want;
      if (!$isunknown(st)) status_hits[st]++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("unexpected result: status %0d, out_id %0d", st, id);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) flag("status", want.status, st);
      if (id !== want.id) flag("out_id", want.id, id);
      if (ws !== want.win_start) flag("out_start", want.win_start, ws);
      if (we !== want.win_end) flag("out_end", want.win_end, we);
      if (last_flag !== want.is_last) flag("is_last", want.is_last, last_flag);
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic [1:0]         action_i       = '0;
  logic signed [31:0] package_id_i   = '0;
  logic signed [31:0] window_start_i = '0;
  logic signed [31:0] window_end_i   = '0;
  logic signed [31:0] now_time_i     = '0;
  logic               busy;
  logic               valid_o;
  logic [2:0]         status_o;
  logic signed [31:0] out_id_o;
  logic signed [31:0] out_start_o;
  logic signed [31:0] out_end_o;
  logic               is_last_o;

  window_queue_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int          quiet_left  = 0;

  deadline_window_queue #(.DEPTH(SLOTS)) uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1)
      sb.check_result(status_o, out_id_o, out_start_o, out_end_o, is_last_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[deadline_window_queue] ERROR");
      $finish;
    end
  end

  // Hold the command until accepted, then idle for a random gap.
  task automatic send(action_e act, logic signed [31:0] id, logic signed [31:0] ws,
                      logic signed [31:0] we, logic signed [31:0] now);
    int gap;
    int pick;
    @(negedge clk_i);
    start          <= 1'b1;
    action_i       <= act;
    package_id_i   <= id;
    window_start_i <= ws;
    window_end_i   <= we;
    now_time_i     <= now;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(act, id, ws, we, now);
    pick = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else if (pick < 4) begin
      quiet_left = $urandom_range(10, 40);
      gap = 0;
    end else if (pick < 50) begin
      gap = 0;
    end else if (pick < 85) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
    repeat (gap) begin
      @(negedge clk_i);
      start          <= 1'b0;
      action_i       <= 2'($urandom_range(0, 3));
      package_id_i   <= $urandom;
      window_start_i <= $urandom;
      window_end_i   <= $urandom;
      now_time_i     <= $urandom;
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int                 i;
    int                 pick;
    int                 base;
    int unsigned        enq_left;
    logic signed [31:0] ws;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queue, extreme ids and windows, inverted and single-point windows
    send(ACT_DEQUEUE, 0, 0, 0, 0);
    send(ACT_PEEK, 0, 0, 0, 0);
    send(ACT_CHECK, 0, 0, 0, 0);
    send(ACT_ENQUEUE, WORD_MAX, WORD_MIN, WORD_MAX, 0);
    send(ACT_PEEK, 0, 0, 0, 0);
    send(ACT_CHECK, 0, 0, 0, 0);
    send(ACT_DEQUEUE, 0, 0, 0, 0);
    send(ACT_ENQUEUE, WORD_MIN, 10, 5, 0);
    send(ACT_CHECK, 0, 0, 0, 5);
    send(ACT_ENQUEUE, 0, 20, 30, 0);
    send(ACT_ENQUEUE, -1, -100, -100, 0);
    send(ACT_CHECK, 0, 0, 0, 6);
    send(ACT_CHECK, 0, 0, 0, 20);
    send(ACT_CHECK, 0, 0, 0, 30);
    send(ACT_CHECK, 0, 0, 0, 31);
    send(ACT_CHECK, 0, 0, 0, WORD_MIN);
    send(ACT_ENQUEUE, 5, WORD_MAX, WORD_MAX, 0);
    send(ACT_ENQUEUE, 6, WORD_MIN, WORD_MIN, 0);
    send(ACT_CHECK, 0, 0, 0, WORD_MAX - 1);
    send(ACT_CHECK, 0, 0, 0, WORD_MAX);
    send(ACT_DEQUEUE, 0, 0, 0, 0);
    send(ACT_CHECK, 0, 0, 0, WORD_MIN);
    send(ACT_PEEK, 0, 0, 0, 0);
    send(ACT_CHECK, 0, 0, 0, WORD_MIN + 1);
    send(ACT_DEQUEUE, 0, 0, 0, 0);
    hold_until_drained();

    // spread the slot budget evenly; windows trail a slowly advancing clock
    base     = int'($urandom_range(0, 2000)) - 1000;
    enq_left = MID_ENQUEUES;
    for (i = 0; i < MID_ITEMS; i++) begin
      if (i % 140 == 70) hold_until_drained();
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, MID_ITEMS - 1 - i) < enq_left) begin
        enq_left--;
        if (pick < 10) begin
          send(ACT_ENQUEUE, $urandom, $urandom, $urandom, $urandom);
        end else begin
          ws = base + $urandom_range(0, 30);
          send(ACT_ENQUEUE, $urandom, ws, ws + $urandom_range(0, 45) - 5, $urandom);
        end
      end else if (pick < 12) begin
        send(ACT_DEQUEUE, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 35) begin
        send(ACT_PEEK, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 45) begin
        send(ACT_CHECK, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send(ACT_CHECK, $urandom, $urandom, $urandom, base + $urandom_range(0, 70) - 15);
        base += $urandom_range(0, 4);
      end
    end

    // empty the queue, use up the last slots, then expire them in one sweep
    while (sb.head_slot < sb.fill_slot)
      send(ACT_DEQUEUE, $urandom, $urandom, $urandom, $urandom);
    while (sb.fill_slot < SLOTS) begin
      ws = base + 100 + $urandom_range(0, 50);
      send(ACT_ENQUEUE, $urandom, ws, ws + $urandom_range(0, 20), $urandom);
    end
    send(ACT_PEEK, $urandom, $urandom, $urandom, $urandom);
    send(ACT_CHECK, $urandom, $urandom, $urandom, base);
    repeat (3) send(ACT_ENQUEUE, $urandom, $urandom, $urandom, $urandom);
    send(ACT_CHECK, $urandom, $urandom, $urandom, WORD_MAX);
    send(ACT_DEQUEUE, $urandom, $urandom, $urandom, $urandom);
    send(ACT_PEEK, $urandom, $urandom, $urandom, $urandom);
    send(ACT_CHECK, $urandom, $urandom, $urandom, $urandom);
    send(ACT_ENQUEUE, $urandom, $urandom, $urandom, $urandom);
    hold_until_drained();

    $display("run covered %0d commands over %0d cycles, slots used %0d of %0d",
             sb.commands_noted, cycle_count, sb.fill_slot, SLOTS);
    $display("results: added %0d full %0d empty %0d delivered %0d front %0d",
             sb.status_hits[ST_ADDED], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_DELIVERED], sb.status_hits[ST_FRONT]);
    $display("         not yet %0d expired %0d",
             sb.status_hits[ST_NOT_YET], sb.status_hits[ST_EXPIRED]);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("[deadline_window_queue] OK");
    end else begin
      $display("[deadline_window_queue] ERROR");
    end
    $finish;
  end

endmodule
